@@ rtl/pmds_pkg.sv @@
// Shared types, constants and multiplier table for the PLL multiplier and divider search.
package pmds_pkg;

  localparam int unsigned FREQ_W    = 27;
  localparam int unsigned INPUT_W   = 25;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DIV_W     = 3;
  localparam int unsigned MULT_W    = 6;
  localparam int unsigned PROD_W    = 2 * FREQ_W;

  localparam logic [IDX_W-1:0]  MULT_LAST       = 4'd8;
  localparam logic [FREQ_W-1:0] VCO_MAX_RESET   = 27'd96000000;
  localparam logic [FREQ_W-1:0] WAIT_LIMIT_HZ   = 27'd16000000;

  // floor(v / 3) == (v * RECIP3) >> RECIP3_SHIFT for every v below 2**27
  localparam logic [FREQ_W-1:0] RECIP3          = 27'h5555556;
  localparam int unsigned       RECIP3_SHIFT    = 28;

  localparam logic [DIV_W-1:0]  DIV_NONE        = 3'd0;
  localparam logic [DIV_W-1:0]  DIV_BY_2        = 3'd2;
  localparam logic [DIV_W-1:0]  DIV_BY_3        = 3'd3;
  localparam logic [DIV_W-1:0]  DIV_BY_4        = 3'd4;

  // Shared multiplier operations
  localparam logic OP_VCO  = 1'b0;
  localparam logic OP_DIV3 = 1'b1;

  typedef struct packed {
    logic               clock_source;
    logic [INPUT_W-1:0] input_hz;
    logic [FREQ_W-1:0]  target_hz;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] achieved_hz;
    logic [IDX_W-1:0]  multiplier_index;
    logic [DIV_W-1:0]  divider;
    logic              found;
    logic              source_echo;
    logic              flash_wait_states;
  } out_item_t;

  function automatic logic [MULT_W-1:0] mult_of(input logic [IDX_W-1:0] idx);
    logic [MULT_W-1:0] m;
    unique case (idx)
      4'd0:    m = 6'd3;
      4'd1:    m = 6'd4;
      4'd2:    m = 6'd6;
      4'd3:    m = 6'd8;
      4'd4:    m = 6'd12;
      4'd5:    m = 6'd16;
      4'd6:    m = 6'd24;
      4'd7:    m = 6'd32;
      4'd8:    m = 6'd48;
      default: m = 6'd0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/pmds_mul_unit.sv @@
// Shared registered multiplier: VCO product or reciprocal divide by three.
module pmds_mul_unit
  import pmds_pkg::*;
(
  input  logic               clk,
  input  logic               op,
  input  logic [IDX_W-1:0]   idx,
  input  logic [INPUT_W-1:0] fin,
  input  logic [FREQ_W-1:0]  vco,
  output logic [PROD_W-1:0]  prod
);

  logic [FREQ_W-1:0] opa;
  logic [FREQ_W-1:0] opb;
  logic [PROD_W-1:0] prod_r;

  assign opa = (op == OP_VCO) ? {{(FREQ_W-INPUT_W){1'b0}}, fin} : vco;
  assign opb = (op == OP_VCO) ? {{(FREQ_W-MULT_W){1'b0}}, mult_of(idx)} : RECIP3;

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  assign prod = prod_r;

endmodule

@@ rtl/pll_mul_div_search.sv @@
// Top level of the PLL multiplier and divider search engine.
//
// A transaction is accepted when start is high and busy is low. The block then
// walks the nine multipliers 3, 4, 6, 8, 12, 16, 24, 32, 48 and, for each, the
// dividers 2, 3 and 4, keeping the highest output frequency that stays within
// the VCO limit and the target (ties go to the later combination). After the
// accept the block forms the first VCO product; then, for each multiplier, it
// uses the single shared multiplier for the VCO product and then for the
// divide by three through a reciprocal, and finally raises the one-cycle
// result strobe. busy stays high while the search runs. The result appears
// on out_item for exactly one cycle with out_valid high; the receiver cannot
// stall it, so it must capture the result in that cycle. The VCO limit
// register is written through cfg_valid/cfg_ready, which is always ready;
// write it only while busy is low and no result is pending.
module pll_mul_div_search
  import pmds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  // result channel
  output logic              out_valid,
  output out_item_t         out_item,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FREQ_W-1:0] cfg_vco_max_hz
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_VCO  = 2'd1;  // first VCO product in flight
  localparam logic [1:0] PH_D2   = 2'd2;  // VCO ready: try divide by 2, start divide by 3
  localparam logic [1:0] PH_D34  = 2'd3;  // quotient ready: try 3 then 4, start next VCO

  logic [1:0]        state_r,   state_nxt;
  logic [IDX_W-1:0]  m_r,       m_nxt;
  logic [FREQ_W-1:0] best_r,    best_nxt;
  logic [IDX_W-1:0]  idx_r,     idx_nxt;
  logic [DIV_W-1:0]  div_r,     div_nxt;
  logic              any_r,     any_nxt;
  logic [FREQ_W-1:0] vco_r,     vco_nxt;
  logic              vco_ok_r,  vco_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FREQ_W-1:0] vco_max_r;
  in_item_t          item_r,    item_nxt;

  logic              mul_op;
  logic [IDX_W-1:0]  mul_idx;
  logic [PROD_W-1:0] prod;

  logic              prod_ok;
  logic [FREQ_W-1:0] f2;
  logic [FREQ_W-1:0] f3;
  logic [FREQ_W-1:0] f4;
  logic              take3;
  logic [FREQ_W-1:0] best3;

  pmds_mul_unit u_mul (
    .clk  (clk),
    .op   (mul_op),
    .idx  (mul_idx),
    .fin  (item_r.input_hz),
    .vco  (prod[FREQ_W-1:0]),
    .prod (prod)
  );

  // VCO product sits in the low bits; nonzero upper bits mean it overflowed and fails
  assign prod_ok = (prod[PROD_W-1:FREQ_W] == '0) && (prod[FREQ_W-1:0] <= vco_max_r);
  assign f2      = {1'b0, prod[FREQ_W-1:1]};
  assign f3      = {{(FREQ_W+RECIP3_SHIFT-PROD_W){1'b0}}, prod[PROD_W-1:RECIP3_SHIFT]};
  assign f4      = {2'b00, vco_r[FREQ_W-1:2]};

  // divide by 3 first, then divide by 4 against the possibly updated best
  assign take3 = vco_ok_r && (f3 <= item_r.target_hz) && (f3 >= best_r);
  assign best3 = take3 ? f3 : best_r;

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    best_nxt      = best_r;
    idx_nxt       = idx_r;
    div_nxt       = div_r;
    any_nxt       = any_r;
    vco_nxt       = vco_r;
    vco_ok_nxt    = vco_ok_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    mul_op        = OP_VCO;
    mul_idx       = m_r;

    unique case (state_r)
      PH_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          best_nxt  = '0;
          idx_nxt   = '0;
          div_nxt   = DIV_NONE;
          any_nxt   = 1'b0;
          m_nxt     = '0;
          state_nxt = PH_VCO;
        end
      end
      PH_VCO: begin
        // launch the product for the first multiplier
        mul_op    = OP_VCO;
        mul_idx   = m_r;
        state_nxt = PH_D2;
      end
      PH_D2: begin
        vco_ok_nxt = prod_ok;
        vco_nxt    = prod[FREQ_W-1:0];
        mul_op     = OP_DIV3;
        if (prod_ok && (f2 <= item_r.target_hz) && (f2 >= best_r)) begin
          best_nxt = f2;
          idx_nxt  = m_r;
          div_nxt  = DIV_BY_2;
          any_nxt  = 1'b1;
        end
        state_nxt = PH_D34;
      end
      PH_D34: begin
        if (take3) begin
          best_nxt = f3;
          idx_nxt  = m_r;
          div_nxt  = DIV_BY_3;
          any_nxt  = 1'b1;
        end
        if (vco_ok_r && (f4 <= item_r.target_hz) && (f4 >= best3)) begin
          best_nxt = f4;
          idx_nxt  = m_r;
          div_nxt  = DIV_BY_4;
          any_nxt  = 1'b1;
        end
        // overlap: start the next VCO product while this one is judged
        mul_op  = OP_VCO;
        mul_idx = IDX_W'(m_r + 4'd1);
        if (m_r == MULT_LAST) begin
          state_nxt     = PH_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          m_nxt     = IDX_W'(m_r + 4'd1);
          state_nxt = PH_D2;
        end
      end
      default: begin
        state_nxt = PH_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      vco_max_r   <= VCO_MAX_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vco_max_r <= cfg_vco_max_hz;
      end
    end
  end

  // search datapath; no reset needed, each register is cleared or loaded in a transaction before use
  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    best_r   <= best_nxt;
    idx_r    <= idx_nxt;
    div_r    <= div_nxt;
    any_r    <= any_nxt;
    vco_r    <= vco_nxt;
    vco_ok_r <= vco_ok_nxt;
    item_r   <= item_nxt;
  end

  assign busy      = (state_r != PH_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // hold the result fields from the search registers; they stay put until the next accept
  assign out_item.achieved_hz       = best_r;
  assign out_item.multiplier_index  = idx_r;
  assign out_item.divider           = div_r;
  assign out_item.found             = any_r;
  assign out_item.source_echo       = item_r.clock_source;
  assign out_item.flash_wait_states = (best_r > WAIT_LIMIT_HZ);

endmodule

@@ rtl/pmds_checker.sv @@
// Port-level assertions for the PLL search engine and their bind.
module pmds_checker
  import pmds_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe not at end of a search");

  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |->
      (out_item.achieved_hz == '0 && out_item.divider == DIV_NONE &&
       out_item.multiplier_index == '0))
    else $error("empty result carries nonzero fields");

  a_found_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |->
      ((out_item.divider == DIV_BY_2 || out_item.divider == DIV_BY_3 ||
        out_item.divider == DIV_BY_4) && out_item.multiplier_index <= MULT_LAST &&
       out_item.flash_wait_states == (out_item.achieved_hz > WAIT_LIMIT_HZ)))
    else $error("found result has inconsistent fields");

endmodule

bind pll_mul_div_search pmds_checker u_pmds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the PLL multiplier and divider search block.
module testbench;
  import pmds_pkg::*;

  // Settle this many cycles once nothing is pending, before a VCO limit change or the end.
  localparam int unsigned SETTLE_CYCLES  = 30;
  // End the run when this many cycles pass without any transaction.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned IDLE_PERCENT   = 36;
  localparam int unsigned RANDOM_PER_SET = 100;

  localparam logic [FREQ_W-1:0]  FREQ_ALL_ONES  = '1;
  localparam logic [INPUT_W-1:0] INPUT_ALL_ONES = '1;
  localparam logic [FREQ_W-1:0]  VCO_LIMIT_LOW  = 27'd24000000;

  // Multipliers tried by the search, in the order of the index field.
  localparam int unsigned PLL_MULTS [0:8] = '{3, 4, 6, 8, 12, 16, 24, 32, 48};
  localparam logic [DIV_W-1:0] PLL_DIVS [0:2] = '{DIV_BY_2, DIV_BY_3, DIV_BY_4};

  // Scoreboard: predicts the chosen PLL setting for each accepted command and
  // checks every result strobe against the oldest prediction.
  class search_scoreboard;
    out_item_t         pending [$];
    logic [FREQ_W-1:0] vco_limit;
    int unsigned       mismatches;

    function new();
      vco_limit  = VCO_MAX_RESET;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Walk every multiplier/divider pair; keep the highest output that fits
    // under both the VCO limit and the target, later pairs winning ties.
    function out_item_t best_pll_setting(in_item_t req);
      out_item_t       r;
      longint unsigned vco;
      longint unsigned f;
      longint unsigned best;
      r    = '0;
      best = 0;
      for (int m = 0; m < 9; m++) begin
        vco = req.input_hz;
        vco = vco * PLL_MULTS[m];
        if (vco > vco_limit) continue;
        for (int j = 0; j < 3; j++) begin
          f = vco / PLL_DIVS[j];
          if (f > req.target_hz) continue;
          if (f >= best) begin
            best               = f;
            r.multiplier_index = IDX_W'(m);
            r.divider          = PLL_DIVS[j];
            r.found            = 1'b1;
          end
        end
      end
      r.achieved_hz       = best[FREQ_W-1:0];
      r.source_echo       = req.clock_source;
      r.flash_wait_states = (best > WAIT_LIMIT_HZ);
      return r;
    endfunction

    function void note_request(in_item_t req);
      pending.push_back(best_pll_setting(req));
    endfunction

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
        return;
      end
      want = pending.pop_front();
      compare_field("achieved_hz", got.achieved_hz, want.achieved_hz);
      compare_field("multiplier_index", got.multiplier_index, want.multiplier_index);
      compare_field("divider", got.divider, want.divider);
      compare_field("found", got.found, want.found);
      compare_field("source_echo", got.source_echo, want.source_echo);
      compare_field("flash_wait_states", got.flash_wait_states, want.flash_wait_states);
    endtask
  endclass

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  in_item_t          in_item        = '0;
  logic              cfg_valid      = 1'b0;
  logic [FREQ_W-1:0] cfg_vco_max_hz = '0;
  logic              busy;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_ready;

  // Suppress idle gaps while set, so back-to-back commands hit the block.
  bit                steady = 1'b0;

  search_scoreboard  sb = new();

  pll_mul_div_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_vco_max_hz (cfg_vco_max_hz)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Capture every result strobe; the block cannot be stalled, so sample at
  // each edge where out_valid was high.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Watchdog: reset the count on any transaction (command, result or
  // register write), otherwise advance it; give up at the limit.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog expired", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle gap in cycles: each cycle idles with the given odds, so gaps of all
  // lengths land on every phase of the search.
  function automatic int unsigned idle_gap();
    int unsigned gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    return gap;
  endfunction

  function automatic in_item_t make_item(logic src, logic [INPUT_W-1:0] fin,
                                         logic [FREQ_W-1:0] tgt);
    in_item_t it;
    it.clock_source = src;
    it.input_hz     = fin;
    it.target_hz    = tgt;
    return it;
  endfunction

  // Draw a command: mostly realistic oscillator rates with targets placed on
  // or right beside a reachable frequency, plus full-range noise and corners.
  function automatic in_item_t random_item();
    in_item_t        it;
    longint unsigned reach;
    int unsigned     mode;
    it.clock_source = 1'($urandom_range(1));
    mode = $urandom_range(9);
    if (mode < 6)      it.input_hz = INPUT_W'($urandom_range(16000000, 1000000));
    else if (mode < 8) it.input_hz = INPUT_W'($urandom());
    else if (mode < 9) it.input_hz = INPUT_W'($urandom_range(64));
    else               it.input_hz = '0;
    mode = $urandom_range(9);
    if (mode < 5) begin
      // Aim at one candidate output, then nudge by -1, 0 or +1.
      reach = it.input_hz;
      reach = reach * PLL_MULTS[$urandom_range(8)] / PLL_DIVS[$urandom_range(2)];
      reach = reach + $urandom_range(2);
      reach = (reach == 0) ? 0 : reach - 1;
      it.target_hz = reach[FREQ_W-1:0];
    end else if (mode < 8) begin
      it.target_hz = FREQ_W'($urandom());
    end else if (mode < 9) begin
      it.target_hz = FREQ_W'($urandom_range(1000));
    end else begin
      it.target_hz = FREQ_W'(WAIT_LIMIT_HZ + $urandom_range(2) - 1);
    end
    return it;
  endfunction

  // Drive one command: idle a random gap, raise start with the payload and
  // hold it until the edge where busy is low, then record the transaction.
  task automatic drive_command(in_item_t it);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(it);
  endtask

  // Drop start, wait for every outstanding result, then settle so the block
  // is truly idle before the VCO limit changes.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vco_limit(logic [FREQ_W-1:0] limit);
    repeat (idle_gap()) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_vco_max_hz <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.vco_limit = limit;
    cfg_valid   <= 1'b0;
  endtask

  task automatic random_commands(int unsigned count);
    repeat (count) drive_command(random_item());
  endtask

  initial begin : stimulus
    logic [FREQ_W-1:0] limits [0:4];
    limits[0] = VCO_LIMIT_LOW;
    limits[1] = '0;
    limits[2] = FREQ_ALL_ONES;
    limits[3] = FREQ_W'($urandom_range(96000000, 24000000));
    limits[4] = VCO_MAX_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners under the reset VCO limit.
    drive_command(make_item(1'b0, '0, '0));                 // zero input, zero target
    drive_command(make_item(1'b1, '0, FREQ_ALL_ONES));      // zero input, any target
    drive_command(make_item(1'b0, INPUT_ALL_ONES, FREQ_ALL_ONES)); // VCO always too high
    drive_command(make_item(1'b1, 25'd1, '0));              // only the zero output fits the target
    drive_command(make_item(1'b0, 25'd2000000, 27'd48000000));  // exact 48 MHz
    drive_command(make_item(1'b1, 25'd2000000, 27'd47999999));  // just under 48 MHz
    drive_command(make_item(1'b0, 25'd8000000, WAIT_LIMIT_HZ)); // at wait-state edge
    drive_command(make_item(1'b1, 25'd16000001, 27'd16000001)); // one above the edge
    drive_command(make_item(1'b0, 25'd6000000, 27'd12000000));  // three-way tie
    drive_command(make_item(1'b1, 25'd1, FREQ_ALL_ONES));
    drive_command(make_item(1'b0, 25'd32000000, FREQ_ALL_ONES)); // VCO exactly at limit
    drive_command(make_item(1'b1, 25'd32000001, FREQ_ALL_ONES)); // one over the limit
    drive_command(make_item(1'b0, 25'd4000000, 27'd24000000));
    drive_command(make_item(1'b1, 25'd1000000, 27'd1));
    drive_command(make_item(1'b0, 25'd12345678, 27'd99999999));
    drive_command(make_item(1'b1, 25'h1555555, 27'h2AAAAAA));
    drive_command(make_item(1'b0, 25'h0AAAAAA, 27'h5555555));
    drive_command(make_item(1'b1, 25'd3000000, '0));
    random_commands(RANDOM_PER_SET);
    drain();

    // Sweep the VCO limit: low end, zero, all ones, a random legal value and
    // back to the reset value. Run the all-ones set with no idle gaps.
    foreach (limits[k]) begin
      write_vco_limit(limits[k]);
      steady = (k == 2);
      if (k == 0) drive_command(make_item(1'b0, 25'd8000000, FREQ_ALL_ONES));
      if (k == 2) drive_command(make_item(1'b1, INPUT_ALL_ONES, FREQ_ALL_ONES));
      random_commands(RANDOM_PER_SET);
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ pll_mul_div_search.f @@
rtl/pmds_pkg.sv
rtl/pmds_mul_unit.sv
rtl/pll_mul_div_search.sv
rtl/pmds_checker.sv
tb/sv/testbench.sv
